// ----- design/class_quota_round_robin_dispatcher_core_defines.svh -----
// Assertion macros used by the bound checker module.
`ifndef CLASS_QUOTA_ROUND_ROBIN_DISPATCHER_CORE_DEFINES_SVH
`define CLASS_QUOTA_ROUND_ROBIN_DISPATCHER_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define CQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/cqrr_pkg.sv -----
package cqrr_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int CLS_W = $clog2(NUM_CLASSES);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCNT_W = $clog2(NUM_CLASSES + 1);
    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int PADDR_W = 5;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_DRAIN  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [1:0] KIND_GRANT    = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_REJ_STOP = 2'd2;
    localparam logic [1:0] KIND_REJ_FULL = 2'd3;

    localparam logic [2:0] REG_LIMIT  = 3'd0;
    localparam logic [2:0] REG_SHARE0 = 3'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  req_class;
        logic [15:0] req_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  grant_class;
        logic [15:0] grant_tag;
        logic [31:0] grant_id;
        logic [7:0]  running_now;
        logic        last;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic       latch;     // capture the input item
        logic       submit;    // write the queue and list the class
        logic       finish;    // decrement running counts
        logic       drain;     // clear queues and list
        logic       start;     // clear pass counter, load slot from saved position
        logic       eval;      // evaluate current slot, read memory
        logic       grant;     // commit the grant of the evaluated slot
        logic       step;      // move to next slot
    } t_ctl_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic       rej_stop;
        logic       rej_full;
        logic       pass_ok;    // a pass may run
        logic       slot_ok;    // evaluated slot can grant
        logic       pass_end;   // last slot visited or limit reached
        logic [1:0] cmd;
    } t_dp_stat;

endpackage

// ----- design/cqrr_ctrl.sv -----
module cqrr_ctrl
    import cqrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd,
    output logic     o_busy,
    output logic     o_emit_grant,
    output logic     o_emit_close,
    output logic [1:0] o_close_kind
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_EVAL, S_CHECK, S_GRANT, S_CLOSE
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        o_cmd = '0;
        o_emit_grant = 1'b0;
        o_emit_close = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_kind = KIND_DONE;
                n_state = S_CLOSE;
                case (i_stat.cmd)
                    CMD_SUBMIT: begin
                        if (i_stat.rej_stop) begin
                            n_kind = KIND_REJ_STOP;
                        end else if (i_stat.rej_full) begin
                            n_kind = KIND_REJ_FULL;
                        end else begin
                            o_cmd.submit = 1'b1;
                            n_state = S_EVAL;
                        end
                    end
                    CMD_FINISH: begin
                        o_cmd.finish = 1'b1;
                        n_state = S_EVAL;
                    end
                    CMD_DRAIN: o_cmd.drain = 1'b1;
                    default: ;
                endcase
                if (n_state == S_EVAL) begin
                    o_cmd.start = 1'b1;
                end
            end
            S_EVAL: begin
                if (!i_stat.pass_ok) begin
                    n_state = S_CLOSE;
                end else begin
                    o_cmd.eval = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.slot_ok) begin
                    n_state = S_GRANT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = i_stat.pass_end ? S_CLOSE : S_EVAL;
                end
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
                o_emit_grant = 1'b1;
                o_cmd.step = 1'b1;
                n_state = i_stat.pass_end ? S_CLOSE : S_EVAL;
            end
            S_CLOSE: begin
                o_emit_close = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_close_kind = r_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind <= KIND_DONE;
        end else begin
            r_state <= n_state;
            r_kind <= n_kind;
        end
    end

endmodule

// ----- design/cqrr_dpath.sv -----
module cqrr_dpath
    import cqrr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_ctl_cmd  i_cmd,
    input  logic      i_emit_grant,
    input  logic      i_emit_close,
    input  logic [1:0] i_close_kind,
    input  logic [7:0] i_limit,
    input  logic [NUM_CLASSES-1:0][11:0] i_share,
    output t_dp_stat  o_stat,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic [15:0] r_mem [MEM_DEPTH];
    logic [15:0] r_rd_tag;

    t_in_item r_item;
    logic [NUM_CLASSES-1:0][QPTR_W-1:0]  r_head;
    logic [NUM_CLASSES-1:0][QFILL_W-1:0] r_fill;
    logic [NUM_CLASSES-1:0][CLS_W-1:0]   r_order;
    logic [OCNT_W-1:0] r_ocnt;
    logic [CLS_W-1:0]  r_rr;
    logic [CLS_W-1:0]  r_slot;
    logic [OCNT_W-1:0] r_visit;
    logic [7:0] r_total;
    logic [NUM_CLASSES-1:0][7:0] r_crun;
    logic [31:0] r_id;
    logic r_accepting;
    logic r_draining;
    logic [CLS_W-1:0] r_cls;
    logic r_ok;
    logic [19:0] r_prod;
    logic r_strobe;
    t_out_item r_out;

    logic [CLS_W-1:0] w_cls;
    logic [11:0] w_share;
    logic [CLS_W:0] w_next_slot;
    logic [11:0] w_ceil;
    logic [11:0] w_allow;
    logic w_listed;
    logic [7:0] w_total_next;

    assign w_cls = r_order[r_slot];
    assign w_share = (i_share[w_cls] == 12'd0) ? 12'd256 : i_share[w_cls];
    // Rounded-up allowance keeps all twelve integer bits of the product.
    assign w_ceil = r_prod[19:8] + {11'd0, |r_prod[7:0]};
    assign w_allow = (w_ceil == 12'd0) ? 12'd1 : w_ceil;
    assign w_total_next = r_total + 8'd1;
    assign w_next_slot = {1'b0, r_slot} + 1'b1;

    always_comb begin
        w_listed = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (OCNT_W'(i) < r_ocnt && r_order[i] == r_item.req_class[CLS_W-1:0]) begin
                w_listed = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.cmd = r_item.cmd;
        o_stat.rej_stop = !r_accepting;
        o_stat.rej_full = r_fill[r_item.req_class[CLS_W-1:0]] >= QFILL_W'(QUEUE_DEPTH);
        o_stat.pass_ok = !r_draining && (r_total < i_limit) && (r_ocnt != '0);
        o_stat.slot_ok = r_ok && ({4'd0, r_crun[r_cls]} < w_allow);
        o_stat.pass_end = (r_visit + 1'b1 >= r_ocnt) ||
                          ((i_emit_grant ? w_total_next : r_total) >= i_limit);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.submit) begin
            r_mem[{r_item.req_class[CLS_W-1:0],
                   QPTR_W'(r_head[r_item.req_class[CLS_W-1:0]]
                   + r_fill[r_item.req_class[CLS_W-1:0]][QPTR_W-1:0])}] <= r_item.req_tag;
        end
        if (i_cmd.eval) begin
            r_rd_tag <= r_mem[{w_cls, r_head[w_cls]}];
            r_cls <= w_cls;
            r_ok <= (r_fill[w_cls] != '0);
            r_prod <= {8'd0, w_share} * {12'd0, i_limit};
        end
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
            r_order <= '0;
            r_ocnt <= '0;
            r_rr <= '0;
            r_slot <= '0;
            r_visit <= '0;
            r_total <= '0;
            r_crun <= '0;
            r_id <= '0;
            r_accepting <= 1'b1;
            r_draining <= 1'b0;
            r_strobe <= 1'b0;
            r_out <= '0;
        end else begin
            r_strobe <= i_emit_grant || i_emit_close;
            if (i_cmd.submit) begin
                r_fill[r_item.req_class[CLS_W-1:0]] <=
                    r_fill[r_item.req_class[CLS_W-1:0]] + 1'b1;
                if (!w_listed) begin
                    r_order[r_ocnt[CLS_W-1:0]] <= r_item.req_class[CLS_W-1:0];
                    r_ocnt <= r_ocnt + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_total != 8'd0) begin
                    r_total <= r_total - 8'd1;
                end
                if (r_crun[r_item.req_class[CLS_W-1:0]] != 8'd0) begin
                    r_crun[r_item.req_class[CLS_W-1:0]] <=
                        r_crun[r_item.req_class[CLS_W-1:0]] - 8'd1;
                end
            end
            if (i_cmd.drain) begin
                r_accepting <= 1'b0;
                r_draining <= 1'b1;
                r_head <= '0;
                r_fill <= '0;
                r_ocnt <= '0;
            end
            if (i_cmd.start) begin
                r_visit <= '0;
                // Saved position is always below the list length, except
                // after a drain empties the list, when no pass can run.
                r_slot <= r_rr;
            end
            if (i_cmd.step) begin
                r_visit <= r_visit + 1'b1;
                r_slot <= (w_next_slot >= (CLS_W+1)'(r_ocnt)) ? '0
                        : w_next_slot[CLS_W-1:0];
            end
            if (i_cmd.grant) begin
                r_head[r_cls] <= r_head[r_cls] + 1'b1;
                r_fill[r_cls] <= r_fill[r_cls] - 1'b1;
                r_total <= w_total_next;
                r_crun[r_cls] <= r_crun[r_cls] + 8'd1;
                r_id <= r_id + 32'd1;
                r_rr <= (w_next_slot >= (CLS_W+1)'(r_ocnt)) ? '0
                      : w_next_slot[CLS_W-1:0];
                r_out.kind <= KIND_GRANT;
                r_out.grant_class <= r_cls;
                r_out.grant_tag <= r_rd_tag;
                r_out.grant_id <= r_id;
                r_out.running_now <= w_total_next;
                r_out.last <= 1'b0;
            end
            if (i_emit_close) begin
                r_out.kind <= i_close_kind;
                r_out.grant_class <= '0;
                r_out.grant_tag <= '0;
                r_out.grant_id <= '0;
                r_out.running_now <= r_total;
                r_out.last <= 1'b1;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

// ----- design/cqrr_regs.sv -----
module cqrr_regs
    import cqrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_limit,
    output logic [NUM_CLASSES-1:0][11:0] o_share
);

    logic [7:0] r_limit;
    logic [NUM_CLASSES-1:0][11:0] r_share;
    logic [2:0] w_idx;

    assign w_idx = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (w_idx == REG_LIMIT) begin
            prdata = {24'd0, r_limit};
        end else if (w_idx >= REG_SHARE0 && w_idx < REG_SHARE0 + 3'(NUM_CLASSES)) begin
            prdata = {20'd0, r_share[2'(w_idx - REG_SHARE0)]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'd4;
            r_share <= {NUM_CLASSES{12'd256}};
        end else if (psel && penable && pwrite) begin
            if (w_idx == REG_LIMIT) begin
                r_limit <= pwdata[7:0];
            end else if (w_idx >= REG_SHARE0 && w_idx < REG_SHARE0 + 3'(NUM_CLASSES)) begin
                r_share[2'(w_idx - REG_SHARE0)] <= pwdata[11:0];
            end
        end
    end

    assign o_limit = r_limit;
    assign o_share = r_share;

endmodule

// ----- design/class_quota_round_robin_dispatcher_core.sv -----
// Channel   | Direction | Handshake                  | Payload
// command   | in        | i_start, o_busy            | i_item (t_in_item)
// result    | out       | o_strobe, one cycle        | o_result (t_out_item)
// config    | in        | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A command is transferred when i_start is high and o_busy is low.
// After the transfer o_busy stays high in DECODE and CLOSE for rejections, drains and
// no-ops, also in EVAL when no pass can run, else also in EVAL and CHECK per visited
// class and GRANT per grant. The closing result shows in the first idle cycle, when
// the next command may transfer. One shared evaluation stage checks the slots in turn.
// Reset is synchronous and active low; the receiver cannot stall results.

module class_quota_round_robin_dispatcher_core
    import cqrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    output logic        o_busy,
    output logic        o_strobe,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_ctl_cmd w_cmd;
    t_dp_stat w_stat;
    logic w_emit_grant;
    logic w_emit_close;
    logic [1:0] w_close_kind;
    logic [7:0] w_limit;
    logic [NUM_CLASSES-1:0][11:0] w_share;

    // Register file for the limit and the per-class shares.
    cqrr_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_limit(w_limit), .o_share(w_share)
    );

    // Sequencer that walks decode, the round-robin pass and the closing result.
    cqrr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_stat(w_stat), .o_cmd(w_cmd),
        .o_busy, .o_emit_grant(w_emit_grant), .o_emit_close(w_emit_close),
        .o_close_kind(w_close_kind)
    );

    // Queues, class list, counters and the result register.
    cqrr_dpath u_dpath (
        .i_clk, .i_rst_n, .i_item, .i_cmd(w_cmd),
        .i_emit_grant(w_emit_grant), .i_emit_close(w_emit_close),
        .i_close_kind(w_close_kind), .i_limit(w_limit), .i_share(w_share),
        .o_stat(w_stat), .o_strobe, .o_result
    );

endmodule

// ----- design/cqrr_checker.sv -----
`include "class_quota_round_robin_dispatcher_core_defines.svh"

module cqrr_checker
    import cqrr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    `CQ_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `CQ_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_strobe && o_result.last, !o_busy)
    `CQ_ASSERT_IMP(a_grant_not_last, i_clk, i_rst_n,
        o_strobe && o_result.kind == KIND_GRANT, !o_result.last)
    `CQ_ASSERT_IMP(a_grant_busy, i_clk, i_rst_n, o_strobe && !o_result.last, o_busy)

endmodule

bind class_quota_round_robin_dispatcher_core cqrr_checker u_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_strobe, .o_result
);

// ----- test/class_quota_round_robin_dispatcher_core_checker.sv -----
`timescale 1ns / 1ps

module class_quota_round_robin_dispatcher_core_checker
    import cqrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    input  logic        i_busy,
    input  logic        i_strobe,
    input  t_out_item   i_result,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int EXP_DEPTH = 64;

    logic [15:0] tag_fifo [NUM_CLASSES][QUEUE_DEPTH];
    logic [3:0]  fifo_head [NUM_CLASSES];
    logic [4:0]  fifo_fill [NUM_CLASSES];
    logic [1:0]  class_order [NUM_CLASSES];
    int          order_len;
    int          rr_slot;
    logic [7:0]  total_running;
    logic [7:0]  per_class_running [NUM_CLASSES];
    logic [31:0] task_seq;
    logic        stopped;
    logic [7:0]  limit_reg;
    logic [11:0] share_reg [NUM_CLASSES];
    t_out_item   expected_buf [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          exp_count;

    assign o_pending = exp_count;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic void add_expected(input t_out_item r);
        expected_buf[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_count++;
    endfunction

    function automatic t_out_item take_expected();
        t_out_item r;
        r = expected_buf[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        exp_count--;
        return r;
    endfunction

    function automatic int class_allowance(input int c);
        int s;
        int a;
        s = (share_reg[c] == 0) ? 256 : share_reg[c];
        a = (s * limit_reg + 255) >> 8;
        return (a == 0) ? 1 : a;
    endfunction

    function automatic t_out_item make_result(input logic [1:0] kind, input logic [1:0] cls,
                                              input logic [15:0] tag, input logic [31:0] id,
                                              input logic last);
        t_out_item r;
        r.kind = kind;
        r.grant_class = cls;
        r.grant_tag = tag;
        r.grant_id = id;
        r.running_now = total_running;
        r.last = last;
        return r;
    endfunction

    task automatic schedule_pass();
        int start_slot;
        int c;
        if (stopped || total_running >= limit_reg || order_len == 0) return;
        start_slot = rr_slot % order_len;
        for (int i = 0; i < order_len && total_running < limit_reg; i++) begin
            c = class_order[(start_slot + i) % order_len];
            if (fifo_fill[c] == 0) continue;
            if (per_class_running[c] >= class_allowance(c)) continue;
            total_running++;
            per_class_running[c]++;
            add_expected(make_result(KIND_GRANT, c[1:0],
                tag_fifo[c][fifo_head[c]], task_seq, 1'b0));
            fifo_head[c]++;
            fifo_fill[c]--;
            task_seq++;
            rr_slot = (start_slot + i + 1) % order_len;
        end
    endtask

    task automatic predict_command(input t_in_item it);
        int c;
        bit listed;
        c = it.req_class;
        if (it.cmd == CMD_SUBMIT) begin
            if (stopped) begin
                add_expected(make_result(KIND_REJ_STOP, '0, '0, '0, 1'b1));
                return;
            end
            if (fifo_fill[c] >= QUEUE_DEPTH) begin
                add_expected(make_result(KIND_REJ_FULL, '0, '0, '0, 1'b1));
                return;
            end
            tag_fifo[c][4'(fifo_head[c] + fifo_fill[c])] = it.req_tag;
            fifo_fill[c]++;
            listed = 0;
            for (int i = 0; i < order_len; i++)
                if (class_order[i] == c) listed = 1;
            if (!listed && order_len < NUM_CLASSES) begin
                class_order[order_len] = 2'(c);
                order_len++;
            end
            schedule_pass();
        end else if (it.cmd == CMD_FINISH) begin
            if (total_running > 0) total_running--;
            if (per_class_running[c] > 0) per_class_running[c]--;
            schedule_pass();
        end else if (it.cmd == CMD_DRAIN) begin
            stopped = 1;
            order_len = 0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                fifo_head[i] = 0;
                fifo_fill[i] = 0;
            end
        end
        add_expected(make_result(KIND_DONE, '0, '0, '0, 1'b1));
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item want;
        if (exp_count == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
            return;
        end
        want = take_expected();
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.grant_class !== want.grant_class)
            report_mismatch($sformatf("class %0d want %0d", got.grant_class, want.grant_class));
        if (got.grant_tag !== want.grant_tag)
            report_mismatch($sformatf("tag %h want %h", got.grant_tag, want.grant_tag));
        if (got.grant_id !== want.grant_id)
            report_mismatch($sformatf("id %0d want %0d", got.grant_id, want.grant_id));
        if (got.running_now !== want.running_now)
            report_mismatch($sformatf("running %0d want %0d", got.running_now, want.running_now));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            order_len = 0;
            rr_slot = 0;
            total_running = 0;
            task_seq = 0;
            stopped = 0;
            limit_reg = 4;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                fifo_head[i] = 0;
                fifo_fill[i] = 0;
                per_class_running[i] = 0;
                share_reg[i] = 256;
            end
            exp_wr = 0;
            exp_rd = 0;
            exp_count = 0;
        end else begin
            if (i_strobe) compare_result(i_result);
            if (i_psel && i_penable && i_pwrite) begin
                if (i_paddr[4:2] == REG_LIMIT)
                    limit_reg = i_pwdata[7:0];
                else if (i_paddr[4:2] < REG_SHARE0 + 3'(NUM_CLASSES))
                    share_reg[i_paddr[4:2] - REG_SHARE0] = i_pwdata[11:0];
            end
            if (i_start && !i_busy) predict_command(i_item);
        end
    end

endmodule

// ----- test/class_quota_round_robin_dispatcher_core_tb.sv -----
`timescale 1ns / 1ps

module class_quota_round_robin_dispatcher_core_tb;
    import cqrr_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    t_in_item           i_item;
    logic               o_busy;
    logic               o_strobe;
    t_out_item          o_result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 error_count;
    int                 pending_count;
    int                 gap_percent;
    logic [15:0]        tag_seed;

    class_quota_round_robin_dispatcher_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .o_strobe(o_strobe), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The checker sees every transfer on all three channels and keeps the score.
    class_quota_round_robin_dispatcher_core_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .i_busy(o_busy), .i_strobe(o_strobe), .i_result(o_result),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_errors(error_count), .o_pending(pending_count)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // A generous ceiling on simulation time; a run that reaches it reports errors.
    initial begin
        #20ms;
        $display("class_quota_round_robin_dispatcher_core_tb: errors");
        $finish;
    end

    // Sends one command. When the sender idles, start drops first; otherwise the
    // next item replaces the previous one once o_busy falls after its transfer.
    task automatic send_command(input logic [1:0] cmd, input logic [1:0] cls,
                                input logic [15:0] tag);
        if ($urandom_range(99) < gap_percent) begin
            i_start <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < gap_percent) @(negedge i_clk);
        end
        i_item <= '{cmd: cmd, req_class: cls, req_tag: tag};
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drops start, waits until every expected result is in, then idles a while.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [7:0] limit, input logic [11:0] s0,
                             input logic [11:0] s1, input logic [11:0] s2,
                             input logic [11:0] s3);
        wait_idle();
        write_register(REG_LIMIT, {24'h0, limit});
        write_register(REG_SHARE0, {20'h0, s0});
        write_register(REG_SHARE0 + 3'd1, {20'h0, s1});
        write_register(REG_SHARE0 + 3'd2, {20'h0, s2});
        write_register(REG_SHARE0 + 3'd3, {20'h0, s3});
    endtask

    // Mostly submits and finishes; finishes balance grants so the pool keeps moving.
    task automatic random_burst(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_command(CMD_SUBMIT, 2'($urandom_range(3)), 16'($urandom));
            else if (pick < 97)
                send_command(CMD_FINISH, 2'($urandom_range(3)), 16'($urandom));
            else
                send_command(CMD_NOP, 2'($urandom_range(3)), 16'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 0;
        i_start = 0;
        i_item = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        gap_percent = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed part at reset settings: tags at both extremes, every class,
        // a no-operation, and a finish with all counts at zero.
        send_command(CMD_FINISH, 2'd2, 16'h0000);
        send_command(CMD_SUBMIT, 2'd0, 16'h0000);
        send_command(CMD_SUBMIT, 2'd3, 16'hFFFF);
        send_command(CMD_SUBMIT, 2'd1, 16'h5A5A);
        send_command(CMD_SUBMIT, 2'd2, 16'hA5A5);
        send_command(CMD_SUBMIT, 2'd2, 16'h1234);
        send_command(CMD_NOP, 2'd3, 16'hFFFF);
        // Fill class 3 beyond its depth to reach the queue-full rejection.
        for (int i = 0; i < 17; i++) send_command(CMD_SUBMIT, 2'd3, 16'(i));
        send_command(CMD_FINISH, 2'd3, 16'h0);

        // Limit of zero with zero shares: allowance rounds up to the minimum.
        write_all(8'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(CMD_SUBMIT, 2'd0, 16'h00FF);
        send_command(CMD_FINISH, 2'd0, 16'h0);
        // Largest limit and largest share for class 0; a lowered limit stalls grants afterward.
        write_all(8'd255, 12'd4095, 12'd1, 12'd128, 12'd2048);
        send_command(CMD_FINISH, 2'd1, 16'h0);
        write_all(8'd1, 12'd256, 12'd256, 12'd256, 12'd256);
        send_command(CMD_FINISH, 2'd0, 16'h0);

        // Random part in four phases with changing quotas between them; the last does not idle.
        write_all(8'd6, 12'd128, 12'd64, 12'd0, 12'd384);
        gap_percent = 36;
        random_burst(100);
        // Hold-off until everything has drained out of the result channel.
        wait_idle();
        write_all(8'd3, 12'd100, 12'd300, 12'd256, 12'd1);
        gap_percent = 58;
        random_burst(100);
        write_all(8'($urandom_range(255)), 12'($urandom_range(4095)),
                  12'($urandom_range(4095)), 12'($urandom_range(4095)),
                  12'($urandom_range(4095)));
        random_burst(20);
        write_all(8'd5, 12'd200, 12'd256, 12'd80, 12'd512);
        gap_percent = 0;
        random_burst(90);

        // Drain, then check that submits bounce and finishes still count down.
        send_command(CMD_DRAIN, 2'd1, 16'hBEEF);
        send_command(CMD_SUBMIT, 2'd1, 16'hCAFE);
        send_command(CMD_FINISH, 2'd1, 16'h0);
        send_command(CMD_FINISH, 2'd0, 16'h0);

        wait_idle();
        if (error_count == 0) begin
            $display("class_quota_round_robin_dispatcher_core_tb: clean");
        end else begin
            $display("class_quota_round_robin_dispatcher_core_tb: errors");
        end
        $finish;
    end

endmodule
